// ----- rtl/core/ubdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ubdc_pkg;

   localparam int BAUD_BITS = 24;
   localparam int CHAN_W    = 2;
   localparam int FAM_W     = 3;
   localparam int QUO_W     = 28;   // widest dividend is 192000000
   localparam int DIV_W     = 18;   // divisor of the second division
   localparam int ENC_W     = 18;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_CHIP_FAMILY = 1'b0;

   localparam logic [FAM_W-1:0] FAM_AM    = 3'd0;
   localparam logic [FAM_W-1:0] FAM_2232H = 3'd4;
   localparam logic [FAM_W-1:0] FAM_4232H = 3'd5;
   localparam logic [FAM_W-1:0] FAM_232H  = 3'd6;

   localparam logic [QUO_W-1:0] AM_CLK     = 28'd24000000;
   localparam logic [QUO_W-1:0] STD_BASE   = 28'd48000000;
   localparam logic [QUO_W-1:0] HS_BASE    = 28'd192000000;
   localparam logic [QUO_W-1:0] AM_MAX_DIV = 28'h1FFF8;
   localparam logic [QUO_W-1:0] STD_MAX    = 28'h20000;
   localparam logic [DIV_W-1:0] STD_CLAMP  = 18'h1FFFF;
   localparam logic [ENC_W-1:0] HS_FLAG    = 18'h20000;
   localparam logic [ENC_W-1:0] AM_ENC_3M  = 18'h1;
   localparam logic [ENC_W-1:0] AM_ENC_2M  = 18'h4001;

   // smallest baud that selects the 120 MHz clock on high-speed chips
   localparam logic [BAUD_BITS-1:0] HS_MIN_BAUD = 24'd733;

   localparam logic [BAUD_BITS-1:0] STD_FAST0 = 24'd3000000;
   localparam logic [BAUD_BITS-1:0] STD_FAST1 = 24'd2000000;
   localparam logic [BAUD_BITS-1:0] STD_FAST2 = 24'd1500000;
   localparam logic [BAUD_BITS-1:0] HS_FAST0  = 24'd12000000;
   localparam logic [BAUD_BITS-1:0] HS_FAST1  = 24'd8000000;
   localparam logic [BAUD_BITS-1:0] HS_FAST2  = 24'd6000000;

   localparam logic [2:0] FRAC_MAP [8] = '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7};
   localparam logic [1:0] AM_UP    [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
   localparam logic [1:0] AM_DOWN  [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3};

   typedef enum logic [1:0] {
      PATH_AM,
      PATH_STD,
      PATH_HS
   } path_type;

   typedef enum logic [1:0] {
      FAST_NONE,
      FAST_TOP,
      FAST_MID,
      FAST_LOW
   } fast_type;

   typedef struct packed {
      logic [BAUD_BITS-1:0] baud_rate;
      logic [CHAN_W-1:0]    channel_number;
   } req_type;

   typedef struct packed {
      logic [15:0]          divisor_word;
      logic [15:0]          index_word;
      logic [BAUD_BITS-1:0] achieved_baud;
   } rsp_type;

   typedef struct packed {
      logic [BAUD_BITS-1:0] baud;
      logic [CHAN_W-1:0]    chan;
      logic                 zero;
      logic                 hs_chip;
      path_type             path;
      fast_type             fast;
   } side1_type;

   typedef struct packed {
      side1_type        s;
      logic [DIV_W-1:0] div0;
      logic [DIV_W-1:0] div1;
   } side2_type;

   function automatic logic [ENC_W-1:0] enc_div(input logic [DIV_W-1:0] d);
      logic [ENC_W-1:0] r;
      r = ENC_W'(d >> 3) | (ENC_W'(FRAC_MAP[d[2:0]]) << 14);
      return r;
   endfunction

   // candidate divisor of the AM path; base is the adjusted first quotient
   function automatic logic [DIV_W-1:0] am_cand(input logic [QUO_W-1:0] t,
                                                 input logic [QUO_W-1:0] base);
      logic [QUO_W-1:0] s;
      logic [DIV_W-1:0] r;
      s = t + QUO_W'(AM_UP[t[2:0]]);
      if (t <= QUO_W'(8)) begin
         r = DIV_W'(8);
      end else if (base < QUO_W'(16)) begin
         r = DIV_W'(16);
      end else if (s > AM_MAX_DIV) begin
         r = AM_MAX_DIV[DIV_W-1:0];
      end else begin
         r = s[DIV_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ubdc_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdc_div_cell import ubdc_pkg::*; #(
   parameter int NW    = QUO_W,
   parameter int DW    = BAUD_BITS,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire logic [LANES-1:0][DW-1:0]    in_rem,
   input  wire logic [LANES-1:0][NW-1:0]    in_num,
   input  wire logic [LANES-1:0][NW-1:0]    in_quo,
   input  wire logic [LANES-1:0][DW-1:0]    in_den,
   input  wire logic [SW-1:0]               in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][DW-1:0]         out_rem,
   output logic [LANES-1:0][NW-1:0]         out_num,
   output logic [LANES-1:0][NW-1:0]         out_quo,
   output logic [LANES-1:0][DW-1:0]         out_den,
   output logic [SW-1:0]                    out_side
);

   logic                     valid_ff;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in, den_ff;
   logic [LANES-1:0][NW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [SW-1:0]            side_ff;

   // one restoring step per lane: shift in the next dividend bit, try the subtract
   always_comb begin
      logic [DW:0] trial;
      logic [DW:0] diff;
      for (int l = 0; l < LANES; l++) begin
         trial = {in_rem[l], in_num[l][NW-1]};
         diff  = trial - {1'b0, in_den[l]};
         if (trial >= {1'b0, in_den[l]}) begin
            rem_in[l] = diff[DW-1:0];
            quo_in[l] = {in_quo[l][NW-2:0], 1'b1};
         end else begin
            rem_in[l] = trial[DW-1:0];
            quo_in[l] = {in_quo[l][NW-2:0], 1'b0};
         end
         num_in[l] = {in_num[l][NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ubdc_div_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdc_div_chain import ubdc_pkg::*; #(
   parameter int NW    = QUO_W,
   parameter int DW    = BAUD_BITS,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     adv,
   input  wire logic                     in_valid,
   input  wire logic [LANES-1:0][NW-1:0] in_num,
   input  wire logic [LANES-1:0][DW-1:0] in_den,
   input  wire logic [SW-1:0]            in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][NW-1:0]      out_quo,
   output logic [SW-1:0]                 out_side
);

   logic                     v_w    [0:NW];
   logic [LANES-1:0][DW-1:0] rem_w  [0:NW];
   logic [LANES-1:0][NW-1:0] num_w  [0:NW];
   logic [LANES-1:0][NW-1:0] quo_w  [0:NW];
   logic [LANES-1:0][DW-1:0] den_w  [0:NW];
   logic [SW-1:0]            side_w [0:NW];

   assign v_w[0]    = in_valid;
   assign rem_w[0]  = '0;
   assign num_w[0]  = in_num;
   assign quo_w[0]  = '0;
   assign den_w[0]  = in_den;
   assign side_w[0] = in_side;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      ubdc_div_cell #(.NW(NW), .DW(DW), .LANES(LANES), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (v_w[k]),
         .in_rem    (rem_w[k]),
         .in_num    (num_w[k]),
         .in_quo    (quo_w[k]),
         .in_den    (den_w[k]),
         .in_side   (side_w[k]),
         .out_valid (v_w[k+1]),
         .out_rem   (rem_w[k+1]),
         .out_num   (num_w[k+1]),
         .out_quo   (quo_w[k+1]),
         .out_den   (den_w[k+1]),
         .out_side  (side_w[k+1])
      );
   end

   assign out_valid = v_w[NW];
   assign out_quo   = quo_w[NW];
   assign out_side  = side_w[NW];

endmodule
`default_nettype wire

// ----- rtl/core/uart_baud_divisor_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  ports                         payload
// req      req_valid / req_ready         req_data (baud_rate, channel_number)
// rsp      rsp_valid / rsp_ready         rsp_data (divisor_word, index_word, achieved_baud)
// csr      csr_psel/penable/pwrite ...   chip_family at byte address 0
//
// One item per cycle unless a held result stalls; the path is 28 cells of the first divider
// (clock / baud), 28 cells of the second pair (clock / divisor), one output register.
// Synchronous reset clears every valid bit and sets chip_family to AM.
// A held result stalls the whole row of cells; req_ready drops only then.
module uart_baud_divisor_calc import ubdc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [FAM_W-1:0] fam_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             adv;

   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = adv;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CHIP_FAMILY) ?
                       CSR_DATA_W'(fam_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fam_ff <= FAM_AM;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == REG_CHIP_FAMILY) begin
         fam_ff <= csr_pwdata[FAM_W-1:0];
      end
   end

   // decode into the first divider
   side1_type            s1_in;
   logic [QUO_W-1:0]     num1;
   always_comb begin
      logic hs;
      hs = (fam_ff == FAM_2232H) || (fam_ff == FAM_4232H) || (fam_ff == FAM_232H);
      s1_in.baud    = req_data.baud_rate;
      s1_in.chan    = req_data.channel_number;
      s1_in.zero    = (req_data.baud_rate == '0);
      s1_in.hs_chip = hs;
      if (hs && req_data.baud_rate >= HS_MIN_BAUD) begin
         s1_in.path = PATH_HS;
      end else if (!hs && fam_ff == FAM_AM) begin
         s1_in.path = PATH_AM;
      end else begin
         s1_in.path = PATH_STD;
      end
      unique case (s1_in.path)
         PATH_AM: begin
            num1       = AM_CLK;
            s1_in.fast = FAST_NONE;
         end
         PATH_HS: begin
            num1 = HS_BASE;
            priority if (req_data.baud_rate >= HS_FAST0) s1_in.fast = FAST_TOP;
            else if (req_data.baud_rate >= HS_FAST1) s1_in.fast = FAST_MID;
            else if (req_data.baud_rate >= HS_FAST2) s1_in.fast = FAST_LOW;
            else s1_in.fast = FAST_NONE;
         end
         default: begin
            num1 = STD_BASE;
            priority if (req_data.baud_rate >= STD_FAST0) s1_in.fast = FAST_TOP;
            else if (req_data.baud_rate >= STD_FAST1) s1_in.fast = FAST_MID;
            else if (req_data.baud_rate >= STD_FAST2) s1_in.fast = FAST_LOW;
            else s1_in.fast = FAST_NONE;
         end
      endcase
   end

   logic                        v1;
   logic [0:0][QUO_W-1:0]       q1;
   side1_type                   s1;

   ubdc_div_chain #(.NW(QUO_W), .DW(BAUD_BITS), .LANES(1), .SW($bits(side1_type))) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_num    (num1),
      .in_den    (req_data.baud_rate),
      .in_side   (s1_in),
      .out_valid (v1),
      .out_quo   (q1),
      .out_side  (s1)
   );

   // divisor selection between the two dividers
   side2_type                  s2_in;
   logic [1:0][QUO_W-1:0]      num2;
   logic [1:0][DIV_W-1:0]      den2;
   always_comb begin
      logic [QUO_W:0]   qr;
      logic [QUO_W-1:0] d_raw, am_base;
      logic [DIV_W-1:0] d_std, t0, t1;
      qr      = {1'b0, q1[0]} + (QUO_W+1)'(1);
      d_raw   = qr[QUO_W:1];
      d_std   = (d_raw > STD_MAX) ? STD_CLAMP : d_raw[DIV_W-1:0];
      am_base = q1[0] - QUO_W'(AM_DOWN[q1[0][2:0]]);
      t0      = am_cand(am_base, am_base);
      t1      = am_cand(am_base + QUO_W'(1), am_base);
      s2_in.s = s1;
      s2_in.div1 = t1;
      num2[1] = AM_CLK + QUO_W'(t1 >> 1);
      den2[1] = t1;
      if (s1.path == PATH_AM) begin
         s2_in.div0 = t0;
         num2[0]    = AM_CLK + QUO_W'(t0 >> 1);
         den2[0]    = t0;
      end else begin
         s2_in.div0 = d_std;
         num2[0]    = (s1.path == PATH_HS) ? HS_BASE : STD_BASE;
         den2[0]    = d_std;
      end
   end

   logic                  v2;
   logic [1:0][QUO_W-1:0] q2;
   side2_type             s2;

   ubdc_div_chain #(.NW(QUO_W), .DW(DIV_W), .LANES(2), .SW($bits(side2_type))) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1),
      .in_num    (num2),
      .in_den    (den2),
      .in_side   (s2_in),
      .out_valid (v2),
      .out_quo   (q2),
      .out_side  (s2)
   );

   // pick, encode and pack the result
   always_comb begin
      logic [QUO_W:0]   br;
      logic [QUO_W-1:0] baud_x, diff0, diff1, best_b;
      logic [DIV_W-1:0] best_d;
      logic [ENC_W-1:0] enc;
      br     = {1'b0, q2[0]} + (QUO_W+1)'(1);
      baud_x = QUO_W'(s2.s.baud);
      diff0  = (q2[0] >= baud_x) ? q2[0] - baud_x : baud_x - q2[0];
      diff1  = (q2[1] >= baud_x) ? q2[1] - baud_x : baud_x - q2[1];
      best_d = s2.div0;
      if (s2.s.path == PATH_AM) begin
         if (diff1 < diff0) begin
            best_d = s2.div1;
            best_b = q2[1];
         end else begin
            best_d = s2.div0;
            best_b = q2[0];
         end
         enc = enc_div(best_d);
         if (enc == AM_ENC_3M) begin
            enc = '0;
         end else if (enc == AM_ENC_2M) begin
            enc = ENC_W'(1);
         end
      end else begin
         best_b = br[QUO_W:1];
         unique case (s2.s.fast)
            FAST_TOP: begin
               enc    = ENC_W'(0);
               best_b = QUO_W'((s2.s.path == PATH_HS) ? HS_FAST0 : STD_FAST0);
            end
            FAST_MID: begin
               enc    = ENC_W'(1);
               best_b = QUO_W'((s2.s.path == PATH_HS) ? HS_FAST1 : STD_FAST1);
            end
            FAST_LOW: begin
               enc    = ENC_W'(2);
               best_b = QUO_W'((s2.s.path == PATH_HS) ? HS_FAST2 : STD_FAST2);
            end
            default: enc = enc_div(best_d);
         endcase
         if (s2.s.path == PATH_HS) begin
            enc = enc | HS_FLAG;
         end
      end
      if (s2.s.zero) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in.divisor_word  = enc[15:0];
         rsp_data_in.achieved_baud = best_b[BAUD_BITS-1:0];
         if (s2.s.hs_chip) begin
            rsp_data_in.index_word = {6'b0, enc[17:16], 5'b0,
                                      {1'b0, s2.s.chan} + 3'd1};
         end else begin
            rsp_data_in.index_word = {14'b0, enc[17:16]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- tb/sv/uart_baud_divisor_calc_tb.sv -----
`timescale 1ns / 1ps
module uart_baud_divisor_calc_tb;
   import ubdc_pkg::*;

   localparam int LATENCY  = 57;
   localparam int WDOG_MAX = 4000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   uart_baud_divisor_calc dut (.*);

   req_type pending_reqs[$];
   rsp_type expected_divs[$];
   logic [FAM_W-1:0] family;
   int mismatches = 0;
   int gap_left;
   int stall_left;
   bit gaps_on;
   bit stalls_on;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 48 and 120 MHz clock paths; returns the achieved baud
   function automatic longint unsigned std_divisor(input longint unsigned baud,
                                                   input longint unsigned clk,
                                                   input longint unsigned cdiv,
                                                   output longint unsigned enc);
      longint unsigned base, q, d, b;
      base = clk * 16 / cdiv;
      if (baud >= clk / cdiv) begin
         enc = 0;
         return clk / cdiv;
      end
      if (baud >= clk / (cdiv + cdiv / 2)) begin
         enc = 1;
         return clk / (cdiv + cdiv / 2);
      end
      if (baud >= clk / (2 * cdiv)) begin
         enc = 2;
         return clk / (2 * cdiv);
      end
      q = base / baud;
      d = q[0] ? q / 2 + 1 : q / 2;
      if (d > 64'h20000) d = 64'h1ffff;
      b = base / d;
      b = b[0] ? b / 2 + 1 : b / 2;
      enc = (d >> 3) | (longint'(FRAC_MAP[d[2:0]]) << 14);
      return b;
   endfunction

   // AM path: try two divisors, keep the closer one
   function automatic longint unsigned am_divisor(input longint unsigned baud,
                                                  output longint unsigned enc);
      longint unsigned base, t, est, diff, best_d, best_b, best_diff;
      best_d = 0;
      best_b = 0;
      best_diff = 0;
      base = 24000000 / baud;
      base -= AM_DOWN[base[2:0]];
      for (int i = 0; i < 2; i++) begin
         t = base + i;
         if (t <= 8) begin
            t = 8;
         end else if (base < 16) begin
            t = 16;
         end else begin
            t += AM_UP[t[2:0]];
            if (t > 64'h1FFF8) t = 64'h1FFF8;
         end
         est = (24000000 + t / 2) / t;
         diff = (est < baud) ? baud - est : est - baud;
         if (i == 0 || diff < best_diff) begin
            best_d = t;
            best_b = est;
            best_diff = diff;
         end
      end
      enc = (best_d >> 3) | (longint'(FRAC_MAP[best_d[2:0]]) << 14);
      if (enc == 1) enc = 0;
      else if (enc == 64'h4001) enc = 1;
      return best_b;
   endfunction

   function automatic rsp_type encode_baud(input req_type r, input logic [FAM_W-1:0] fam);
      longint unsigned baud, enc, best, idx;
      bit hs;
      rsp_type o;
      baud = r.baud_rate;
      enc = 0;
      hs = (fam == FAM_2232H || fam == FAM_4232H || fam == FAM_232H);
      if (baud == 0) return '0;
      if (hs) begin
         if (baud * 10 > 120000000 / 16'h3fff) begin
            best = std_divisor(baud, 120000000, 10, enc);
            enc |= 64'h20000;
         end else begin
            best = std_divisor(baud, 48000000, 16, enc);
         end
      end else if (fam == FAM_AM) begin
         best = am_divisor(baud, enc);
      end else begin
         best = std_divisor(baud, 48000000, 16, enc);
      end
      if (hs) idx = ((enc >> 8) & 64'hFF00) | (r.channel_number + 1);
      else idx = (enc >> 16) & 64'hFFFF;
      o.divisor_word = enc[15:0];
      o.index_word = idx[15:0];
      o.achieved_baud = best[BAUD_BITS-1:0];
      return o;
   endfunction

   // sender: one item per handshake, random gap after each accepted item when gaps_on is set
   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (!(req_valid && !req_ready)) begin
         int g;
         g = gap_left;
         if (req_valid) begin
            expected_divs = {expected_divs, encode_baud(req_data, family)};
            g = gaps_on ? $urandom_range(0, 17) : 0;
         end
         nv = 1'b0;
         if (g > 0) begin
            g--;
         end else if (pending_reqs.size() > 0) begin
            nv = 1'b1;
            req_data <= pending_reqs.pop_front();
         end
         gap_left <= g;
         req_valid <= nv;
      end
   end

   // receiver: check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      int s;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         s = stall_left;
         if (rsp_valid && rsp_ready) begin
            if (expected_divs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               want = expected_divs.pop_front();
               if (rsp_data.divisor_word !== want.divisor_word ||
                   rsp_data.index_word !== want.index_word ||
                   rsp_data.achieved_baud !== want.achieved_baud) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: div %h/%h idx %h/%h baud %0d/%0d (exp/got)",
                              want.divisor_word, rsp_data.divisor_word,
                              want.index_word, rsp_data.index_word,
                              want.achieved_baud, rsp_data.achieved_baud);
               end
            end
            s = stalls_on ? $urandom_range(0, 17) : 0;
         end
         if (s > 0) begin
            s--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         stall_left <= s;
      end
   end

   // watchdog: no handshake for too long while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_reqs.size() == 0 && expected_divs.size() == 0 && !req_valid)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_divs.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_family(input logic [FAM_W-1:0] fam);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {$urandom} & ~32'h7 | 32'(fam);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      family = fam;
   endtask

   task automatic queue_item(input logic [BAUD_BITS-1:0] b, input logic [1:0] ch);
      req_type r;
      r.baud_rate = b;
      r.channel_number = ch;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic queue_edges();
      logic [BAUD_BITS-1:0] bauds[$];
      bauds = '{0, 1, 24'hFFFFFF, 12000000, 8000000, 6000000, 3000000, 2000000,
                1500000, 1000000, 732, 733, 734, 183, 184, 366, 9600, 115200, 300,
                11999999, 5999999, 1499999, 23437};
      foreach (bauds[i]) queue_item(bauds[i], 2'(i));
   endtask

   task automatic queue_random(input int n);
      logic [BAUD_BITS-1:0] b;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: b = BAUD_BITS'($urandom);
            1: b = BAUD_BITS'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
            2: b = BAUD_BITS'($urandom_range(1, 20000));
            default: b = BAUD_BITS'($urandom_range(1000000, 13000000));
         endcase
         queue_item(b, 2'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      family = FAM_AM;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset default first, no register write yet
      @(negedge clock);
      queue_edges();
      drain();
      for (int f = 0; f < 8; f++) begin
         write_family(FAM_W'(f));
         gaps_on = $urandom_range(0, 1);
         stalls_on = $urandom_range(0, 1);
         @(negedge clock);
         queue_edges();
         drain();
      end
      for (int p = 0; p < 12; p++) begin
         write_family(p < 2 ? FAM_W'(p * 7) : FAM_W'($urandom));
         gaps_on = (p % 3) != 0;
         stalls_on = (p % 4) != 1;
         @(negedge clock);
         queue_random(133);
         drain();
      end

      if (mismatches == 0 && expected_divs.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/core/ubdc_pkg.sv
rtl/core/ubdc_div_cell.sv
rtl/core/ubdc_div_chain.sv
rtl/core/uart_baud_divisor_calc.sv
tb/sv/uart_baud_divisor_calc_tb.sv
